[hdl/tccv_pkg.sv]
`timescale 1ns / 1ps

package tccv_pkg;

  localparam int XW        = 32;
  localparam int OPW       = 34;
  localparam int PW        = 2 * OPW;
  localparam int FRAC      = 16;
  localparam int DIV_STEPS = OPW + FRAC;
  localparam int MUL_STEPS = OPW;
  localparam int NSLOT     = 5;

  localparam logic [1:0] CFG_NEAR_W  = 2'd0;
  localparam logic [1:0] CFG_CULL    = 2'd1;
  localparam logic [1:0] CFG_WIDTH   = 2'd2;
  localparam logic [1:0] CFG_HEIGHT  = 2'd3;

  localparam logic [1:0] CULL_BACK_ONLY = 2'd1;
  localparam logic [1:0] CULL_DROP_BACK = 2'd2;

  localparam logic [2:0] FLD_X = 3'd0;
  localparam logic [2:0] FLD_Y = 3'd1;
  localparam logic [2:0] FLD_Z = 3'd2;
  localparam logic [2:0] FLD_U = 3'd3;
  localparam logic [2:0] FLD_V = 3'd4;

  localparam logic [2:0] SLOT_V2 = 3'd2;
  localparam logic [2:0] SLOT_C0 = 3'd3;
  localparam logic [2:0] SLOT_C1 = 3'd4;

  localparam logic [30:0] NEAR_RESET   = 31'd6554;
  localparam logic [12:0] WIDTH_RESET  = 13'd640;
  localparam logic [12:0] HEIGHT_RESET = 13'd480;

  localparam logic [XW-1:0] S32_MAX  = 32'h7fff_ffff;
  localparam logic [XW-1:0] S32_MIN  = 32'h8000_0000;
  localparam logic [XW-1:0] SD_MIN   = 32'h8000_0001;
  localparam logic [OPW-1:0] Q_ONE   = 34'd65536;

  typedef logic [2:0] slot_t;

  typedef struct packed {
    logic [XW-1:0] x;
    logic [XW-1:0] y;
    logic [XW-1:0] z;
    logic [XW-1:0] w;
    logic [XW-1:0] u;
    logic [XW-1:0] v;
    logic [15:0]   s;
  } vtx_t;

  typedef struct packed {
    logic           start;
    logic [OPW-1:0] a;
    logic [OPW-1:0] b;
  } arith_req_t;

  typedef struct packed {
    logic          done;
    logic [XW-1:0] q;
  } div_rsp_t;

  typedef struct packed {
    logic          done;
    logic [PW-1:0] p;
  } mul_rsp_t;

  typedef enum logic [4:0] {
    S_IDLE, S_CLASS,
    S_XLA, S_XLB, S_XT, S_XTW, S_XM, S_XMW, S_XWR,
    S_EL, S_EDX, S_EDXW, S_EDY, S_EDYW, S_EC1, S_EC1W, S_EC2, S_EC2W,
    S_OCHK, S_OL, S_OMX, S_OMXW, S_OMY, S_OMYW, S_OUT
  } state_t;

  function automatic logic [XW-1:0] sat32(input logic [PW-1:0] v);
    logic [XW-1:0] r;
    if ((&v[PW-1:XW-1]) || !(|v[PW-1:XW-1])) r = v[XW-1:0];
    else if (v[PW-1]) r = S32_MIN;
    else r = S32_MAX;
    return r;
  endfunction

  // Clamp an edge difference to the symmetric range +-(2^31-1).
  function automatic logic [XW-1:0] satd(input logic [XW:0] v);
    logic [XW-1:0] r;
    if (!v[XW] && v[XW-1]) r = S32_MAX;
    else if (v[XW] && (!v[XW-1] || v[XW-2:0] == '0)) r = SD_MIN;
    else r = v[XW-1:0];
    return r;
  endfunction

  function automatic logic [OPW-1:0] sx34(input logic [XW-1:0] v);
    return {{(OPW-XW){v[XW-1]}}, v};
  endfunction

  function automatic logic [XW-1:0] vtx_field(input vtx_t vt, input logic [2:0] f);
    logic [XW-1:0] r;
    case (f)
      FLD_X:   r = vt.x;
      FLD_Y:   r = vt.y;
      FLD_Z:   r = vt.z;
      FLD_U:   r = vt.u;
      FLD_V:   r = vt.v;
      default: r = vt.x;
    endcase
    return r;
  endfunction

endpackage

[hdl/tccv_if.sv]
`timescale 1ns / 1ps

interface tccv_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] clip_x;
  logic [31:0] clip_y;
  logic [31:0] clip_z;
  logic [31:0] clip_w;
  logic [31:0] tex_u;
  logic [31:0] tex_v;
  logic [15:0] shade;

  modport source (output valid, clip_x, clip_y, clip_z, clip_w, tex_u, tex_v, shade,
                  input ready);
  modport sink (input valid, clip_x, clip_y, clip_z, clip_w, tex_u, tex_v, shade,
                output ready);
endinterface

interface tccv_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] screen_x;
  logic [31:0] screen_y;
  logic [31:0] out_z;
  logic [31:0] out_w;
  logic [31:0] out_u;
  logic [31:0] out_v;
  logic [15:0] out_shade;
  logic [1:0]  corner;
  logic        last_vertex;

  modport source (output valid, screen_x, screen_y, out_z, out_w, out_u, out_v,
                  out_shade, corner, last_vertex, input ready);
  modport sink (input valid, screen_x, screen_y, out_z, out_w, out_u, out_v,
                out_shade, corner, last_vertex, output ready);
endinterface

[hdl/triangle_clip_cull_viewport_core.sv]
`timescale 1ns / 1ps
// Channel  | Dir | Word
// in_vtx   | in  | one clip-space vertex: clip_x/y/z/w, tex_u/v, shade
// out_vtx  | out | one viewport vertex: screen_x/y, out_z/w/u/v, out_shade,
//          |     |   corner, last_vertex
// cfg_*    | in  | register write: cfg_we, cfg_index, cfg_data
//
// The first two vertices of a triangle are taken in one cycle each. The third
// runs the shared 50-step divider and 34-step multiplier under the sequencer,
// for both triangles when a clip yields two, and an output stall holds it.
// in_vtx is not ready from the third vertex until its last word is taken or
// the triangle is dropped. Reset is synchronous, active low.
module triangle_clip_cull_viewport_core import tccv_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  tccv_in_if.sink     in_vtx,
  tccv_out_if.source  out_vtx,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [30:0] cfg_data
);

  state_t state_r, state_nxt;

  logic [30:0] near_r;
  logic [1:0]  cull_r;
  logic [12:0] sw_r, sh_r;

  vtx_t pool_r [NSLOT];
  logic  pool_we;
  slot_t pool_wa;
  vtx_t  pool_wd;

  logic [1:0] cnt_r, cnt_nxt;
  logic       xi_r, xi_nxt;
  logic [2:0] fi_r, fi_nxt;
  logic       ti_r, ti_nxt;
  logic [1:0] k_r, k_nxt;
  logic [1:0] ntri_r, ntri_nxt;
  logic       ncl_r, ncl_nxt;
  slot_t      xa_r [2], xa_nxt [2];
  slot_t      xb_r [2], xb_nxt [2];
  slot_t      tri_r [2][3], tri_nxt [2][3];
  vtx_t       va_r, va_nxt;
  vtx_t       vb_r, vb_nxt;
  vtx_t       rx_r, rx_nxt;
  logic [XW-1:0] t_r, t_nxt;
  logic [XW-1:0] nx_r [2][3], nx_nxt [2][3];
  logic [XW-1:0] ny_r [2][3], ny_nxt [2][3];
  logic [PW-1:0] p1_r, p1_nxt;
  logic       keep_r [2], keep_nxt [2];
  logic       back_r [2], back_nxt [2];
  logic [XW-1:0] sx_r, sx_nxt;
  logic       ovalid_r, ovalid_nxt;
  logic [XW-1:0] ox_r, ox_nxt, oy_r, oy_nxt;
  vtx_t       ov_r, ov_nxt;
  logic [1:0] ocorner_r, ocorner_nxt;
  logic       olast_r, olast_nxt;

  arith_req_t div_req, mul_req;
  div_rsp_t   div_rsp;
  mul_rsp_t   mul_rsp;

  tccv_div u_div (.clk(clk), .rst_n(rst_n), .req(div_req), .rsp(div_rsp));
  tccv_mul u_mul (.clk(clk), .rst_n(rst_n), .req(mul_req), .rsp(mul_rsp));

  slot_t rd_idx;
  vtx_t  rd_v;
  logic  in_fire;
  vtx_t  in_v;

  logic [2:0] outside;
  slot_t      vin_l [3], vout_l [3];
  logic [1:0] nin, nout;

  logic [XW-1:0] e1x, e1y, e2x, e2y;
  logic          rej;
  logic          back;
  logic [1:0]    sk;
  logic [XW-1:0] fa, fb;
  logic [51:0]   lq, lsum;
  logic [66:0]   vq;
  logic [XW-1:0] vp_res;
  logic          is_last;

  assign in_fire = in_vtx.valid && in_vtx.ready;
  assign in_vtx.ready = (state_r == S_IDLE);

  assign in_v = '{x: in_vtx.clip_x, y: in_vtx.clip_y, z: in_vtx.clip_z, w: in_vtx.clip_w,
                  u: in_vtx.tex_u, v: in_vtx.tex_v, s: in_vtx.shade};

  assign sk = back_r[ti_r] ? (2'd2 - k_r) : k_r;

  always_comb begin
    case (state_r)
      S_XLA:   rd_idx = xa_r[xi_r];
      S_XLB:   rd_idx = xb_r[xi_r];
      S_EL:    rd_idx = tri_r[ti_r][k_r];
      S_OL:    rd_idx = tri_r[ti_r][sk];
      default: rd_idx = '0;
    endcase
  end
  assign rd_v = pool_r[rd_idx];

  // Sort the three vertices into inside and outside lists, keeping order.
  always_comb begin
    nin  = '0;
    nout = '0;
    for (int i = 0; i < 3; i++) begin
      vin_l[i]  = '0;
      vout_l[i] = '0;
    end
    for (int i = 0; i < 3; i++) begin
      outside[i] = $signed(pool_r[i].w) < $signed({1'b0, near_r});
      if (outside[i]) begin
        vout_l[nout] = slot_t'(i);
        nout = nout + 1'b1;
      end else begin
        vin_l[nin] = slot_t'(i);
        nin = nin + 1'b1;
      end
    end
  end

  always_comb begin
    e1x = satd({nx_r[ti_r][1][XW-1], nx_r[ti_r][1]} - {nx_r[ti_r][0][XW-1], nx_r[ti_r][0]});
    e1y = satd({ny_r[ti_r][1][XW-1], ny_r[ti_r][1]} - {ny_r[ti_r][0][XW-1], ny_r[ti_r][0]});
    e2x = satd({nx_r[ti_r][2][XW-1], nx_r[ti_r][2]} - {nx_r[ti_r][0][XW-1], nx_r[ti_r][0]});
    e2y = satd({ny_r[ti_r][2][XW-1], ny_r[ti_r][2]} - {ny_r[ti_r][0][XW-1], ny_r[ti_r][0]});
    rej = 1'b1;
    begin
      logic lx, hx, ly, hy;
      lx = 1'b1; hx = 1'b1; ly = 1'b1; hy = 1'b1;
      for (int j = 0; j < 3; j++) begin
        lx &= $signed(nx_r[ti_r][j]) < -32'sd65536;
        hx &= $signed(nx_r[ti_r][j]) >  32'sd65536;
        ly &= $signed(ny_r[ti_r][j]) < -32'sd65536;
        hy &= $signed(ny_r[ti_r][j]) >  32'sd65536;
      end
      rej = lx | hx | ly | hy;
    end
    back = $signed(p1_r) > $signed(mul_rsp.p);
  end

  // Interpolation: b + t*(b-a)/65536, truncated toward zero.
  always_comb begin
    fa = vtx_field(va_r, fi_r);
    fb = vtx_field(vb_r, fi_r);
    lq = mul_rsp.p[PW-1:FRAC] + 52'((mul_rsp.p[PW-1] && (|mul_rsp.p[FRAC-1:0])) ? 1 : 0);
    lsum = {{20{fb[XW-1]}}, fb} + lq;
    vq = mul_rsp.p[PW-1:1] + 67'((mul_rsp.p[PW-1] && mul_rsp.p[0]) ? 1 : 0);
    vp_res = sat32({vq[66], vq});
  end

  assign is_last = (k_r == 2'd2) && !(!ti_r && ntri_r == 2'd2 && keep_r[1]);

  always_comb begin
    div_req = '0;
    case (state_r)
      S_XT: begin
        div_req.start = 1'b1;
        div_req.a = {3'b000, near_r} - sx34(vb_r.w);
        div_req.b = sx34(vb_r.w) - sx34(va_r.w);
      end
      S_EDX: begin
        div_req.start = 1'b1;
        div_req.a = sx34(vb_r.x);
        div_req.b = sx34(vb_r.w);
      end
      S_EDY: begin
        div_req.start = 1'b1;
        div_req.a = sx34(vb_r.y);
        div_req.b = sx34(vb_r.w);
      end
      default: div_req = '0;
    endcase
  end

  always_comb begin
    mul_req = '0;
    case (state_r)
      S_XM: begin
        mul_req.start = 1'b1;
        mul_req.a = sx34(t_r);
        mul_req.b = sx34(fb) - sx34(fa);
      end
      S_EC1: begin
        mul_req.start = 1'b1;
        mul_req.a = sx34(e2x);
        mul_req.b = sx34(e1y);
      end
      S_EC2: begin
        mul_req.start = 1'b1;
        mul_req.a = sx34(e2y);
        mul_req.b = sx34(e1x);
      end
      S_OMX: begin
        mul_req.start = 1'b1;
        mul_req.a = sx34(nx_r[ti_r][sk]) + Q_ONE;
        mul_req.b = {{(OPW-13){1'b0}}, sw_r};
      end
      S_OMY: begin
        mul_req.start = 1'b1;
        mul_req.a = sx34(ny_r[ti_r][sk]) + Q_ONE;
        mul_req.b = {{(OPW-13){1'b0}}, sh_r};
      end
      default: mul_req = '0;
    endcase
  end

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    xi_nxt      = xi_r;
    fi_nxt      = fi_r;
    ti_nxt      = ti_r;
    k_nxt       = k_r;
    ntri_nxt    = ntri_r;
    ncl_nxt     = ncl_r;
    xa_nxt      = xa_r;
    xb_nxt      = xb_r;
    tri_nxt     = tri_r;
    va_nxt      = va_r;
    vb_nxt      = vb_r;
    rx_nxt      = rx_r;
    t_nxt       = t_r;
    nx_nxt      = nx_r;
    ny_nxt      = ny_r;
    p1_nxt      = p1_r;
    keep_nxt    = keep_r;
    back_nxt    = back_r;
    sx_nxt      = sx_r;
    ovalid_nxt  = ovalid_r;
    ox_nxt      = ox_r;
    oy_nxt      = oy_r;
    ov_nxt      = ov_r;
    ocorner_nxt = ocorner_r;
    olast_nxt   = olast_r;
    pool_we     = 1'b0;
    pool_wa     = '0;
    pool_wd     = in_v;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          pool_we = 1'b1;
          if (cnt_r >= 2'd2) begin
            pool_wa   = SLOT_V2;
            cnt_nxt   = '0;
            state_nxt = S_CLASS;
          end else begin
            pool_wa = {2'b00, cnt_r[0]};
            cnt_nxt = cnt_r + 1'b1;
          end
        end
      end
      S_CLASS: begin
        xi_nxt = 1'b0;
        ti_nxt = 1'b0;
        k_nxt  = '0;
        case (nout)
          2'd0: begin
            ntri_nxt = 2'd1;
            ncl_nxt  = 1'b0;
            tri_nxt[0][0] = 3'd0;
            tri_nxt[0][1] = 3'd1;
            tri_nxt[0][2] = 3'd2;
            state_nxt = S_EL;
          end
          2'd1: begin
            ntri_nxt = 2'd2;
            ncl_nxt  = 1'b1;
            xa_nxt[0] = vin_l[1];
            xb_nxt[0] = vout_l[0];
            xa_nxt[1] = vout_l[0];
            xb_nxt[1] = vin_l[0];
            tri_nxt[0][0] = vin_l[0];
            tri_nxt[0][1] = SLOT_C0;
            tri_nxt[0][2] = SLOT_C1;
            tri_nxt[1][0] = vin_l[0];
            tri_nxt[1][1] = vin_l[1];
            tri_nxt[1][2] = SLOT_C0;
            state_nxt = S_XLA;
          end
          2'd2: begin
            ntri_nxt = 2'd1;
            ncl_nxt  = 1'b1;
            xa_nxt[0] = vin_l[0];
            xb_nxt[0] = vout_l[0];
            xa_nxt[1] = vout_l[1];
            xb_nxt[1] = vin_l[0];
            tri_nxt[0][0] = vin_l[0];
            tri_nxt[0][1] = SLOT_C0;
            tri_nxt[0][2] = SLOT_C1;
            state_nxt = S_XLA;
          end
          default: begin
            ntri_nxt  = '0;
            state_nxt = S_IDLE;
          end
        endcase
      end
      S_XLA: begin
        va_nxt    = rd_v;
        rx_nxt    = rd_v;
        state_nxt = S_XLB;
      end
      S_XLB: begin
        vb_nxt    = rd_v;
        state_nxt = S_XT;
      end
      S_XT: state_nxt = S_XTW;
      S_XTW: begin
        if (div_rsp.done) begin
          t_nxt     = div_rsp.q;
          fi_nxt    = FLD_X;
          state_nxt = S_XM;
        end
      end
      S_XM: state_nxt = S_XMW;
      S_XMW: begin
        if (mul_rsp.done) begin
          case (fi_r)
            FLD_X:   rx_nxt.x = sat32({{16{lsum[51]}}, lsum});
            FLD_Y:   rx_nxt.y = sat32({{16{lsum[51]}}, lsum});
            FLD_Z:   rx_nxt.z = sat32({{16{lsum[51]}}, lsum});
            FLD_U:   rx_nxt.u = sat32({{16{lsum[51]}}, lsum});
            default: rx_nxt.v = sat32({{16{lsum[51]}}, lsum});
          endcase
          if (fi_r == FLD_V) begin
            state_nxt = S_XWR;
          end else begin
            fi_nxt    = fi_r + 1'b1;
            state_nxt = S_XM;
          end
        end
      end
      S_XWR: begin
        pool_we   = 1'b1;
        pool_wa   = xi_r ? SLOT_C1 : SLOT_C0;
        pool_wd   = rx_r;
        pool_wd.w = {1'b0, near_r};
        if (!xi_r) begin
          xi_nxt    = 1'b1;
          state_nxt = S_XLA;
        end else begin
          ti_nxt    = 1'b0;
          k_nxt     = '0;
          state_nxt = S_EL;
        end
      end
      S_EL: begin
        vb_nxt    = rd_v;
        state_nxt = S_EDX;
      end
      S_EDX: state_nxt = S_EDXW;
      S_EDXW: begin
        if (div_rsp.done) begin
          nx_nxt[ti_r][k_r] = div_rsp.q;
          state_nxt = S_EDY;
        end
      end
      S_EDY: state_nxt = S_EDYW;
      S_EDYW: begin
        if (div_rsp.done) begin
          ny_nxt[ti_r][k_r] = div_rsp.q;
          if (k_r == 2'd2) begin
            state_nxt = S_EC1;
          end else begin
            k_nxt     = k_r + 1'b1;
            state_nxt = S_EL;
          end
        end
      end
      S_EC1: state_nxt = S_EC1W;
      S_EC1W: begin
        if (mul_rsp.done) begin
          p1_nxt    = mul_rsp.p;
          state_nxt = S_EC2;
        end
      end
      S_EC2: state_nxt = S_EC2W;
      S_EC2W: begin
        if (mul_rsp.done) begin
          back_nxt[ti_r] = back;
          keep_nxt[ti_r] = !rej && !(cull_r == CULL_BACK_ONLY && !back)
                           && !(cull_r == CULL_DROP_BACK && back);
          k_nxt = '0;
          if (!ti_r && ntri_r == 2'd2) begin
            ti_nxt    = 1'b1;
            state_nxt = S_EL;
          end else begin
            ti_nxt    = 1'b0;
            state_nxt = S_OCHK;
          end
        end
      end
      S_OCHK: begin
        k_nxt = '0;
        if (keep_r[ti_r]) begin
          state_nxt = S_OL;
        end else if (!ti_r && ntri_r == 2'd2) begin
          ti_nxt = 1'b1;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_OL: begin
        vb_nxt    = rd_v;
        state_nxt = S_OMX;
      end
      S_OMX: state_nxt = S_OMXW;
      S_OMXW: begin
        if (mul_rsp.done) begin
          sx_nxt    = vp_res;
          state_nxt = S_OMY;
        end
      end
      S_OMY: state_nxt = S_OMYW;
      S_OMYW: begin
        if (mul_rsp.done) begin
          ovalid_nxt  = 1'b1;
          ox_nxt      = sx_r;
          oy_nxt      = vp_res;
          ov_nxt      = vb_r;
          ocorner_nxt = k_r;
          olast_nxt   = is_last;
          state_nxt   = S_OUT;
        end
      end
      S_OUT: begin
        if (out_vtx.ready) begin
          ovalid_nxt = 1'b0;
          if (olast_r) begin
            state_nxt = S_IDLE;
          end else if (k_r == 2'd2) begin
            ti_nxt    = 1'b1;
            k_nxt     = '0;
            state_nxt = S_OCHK;
          end else begin
            k_nxt     = k_r + 1'b1;
            state_nxt = S_OL;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cnt_r    <= '0;
      ovalid_r <= 1'b0;
      near_r   <= NEAR_RESET;
      cull_r   <= '0;
      sw_r     <= WIDTH_RESET;
      sh_r     <= HEIGHT_RESET;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      ovalid_r <= ovalid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_NEAR_W: near_r <= cfg_data;
          CFG_CULL:   cull_r <= cfg_data[1:0];
          CFG_WIDTH:  sw_r   <= cfg_data[12:0];
          CFG_HEIGHT: sh_r   <= cfg_data[12:0];
          default:    near_r <= near_r;
        endcase
      end
    end
    xi_r      <= xi_nxt;
    fi_r      <= fi_nxt;
    ti_r      <= ti_nxt;
    k_r       <= k_nxt;
    ntri_r    <= ntri_nxt;
    ncl_r     <= ncl_nxt;
    xa_r      <= xa_nxt;
    xb_r      <= xb_nxt;
    tri_r     <= tri_nxt;
    va_r      <= va_nxt;
    vb_r      <= vb_nxt;
    rx_r      <= rx_nxt;
    t_r       <= t_nxt;
    nx_r      <= nx_nxt;
    ny_r      <= ny_nxt;
    p1_r      <= p1_nxt;
    keep_r    <= keep_nxt;
    back_r    <= back_nxt;
    sx_r      <= sx_nxt;
    ox_r      <= ox_nxt;
    oy_r      <= oy_nxt;
    ov_r      <= ov_nxt;
    ocorner_r <= ocorner_nxt;
    olast_r   <= olast_nxt;
  end

  always_ff @(posedge clk) begin
    if (pool_we) pool_r[pool_wa] <= pool_wd;
  end

  assign out_vtx.valid       = ovalid_r;
  assign out_vtx.screen_x    = ox_r;
  assign out_vtx.screen_y    = oy_r;
  assign out_vtx.out_z       = ov_r.z;
  assign out_vtx.out_w       = ov_r.w;
  assign out_vtx.out_u       = ov_r.u;
  assign out_vtx.out_v       = ov_r.v;
  assign out_vtx.out_shade   = ov_r.s;
  assign out_vtx.corner      = ocorner_r;
  assign out_vtx.last_vertex = olast_r;

`ifndef NO_ASSERTIONS
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    in_vtx.ready |-> !out_vtx.valid)
    else $error("input ready while a word is pending");

  a_one_unit: assert property (@(posedge clk) disable iff (!rst_n)
    !(div_req.start && mul_req.start))
    else $error("divider and multiplier started together");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_vtx.valid && out_vtx.ready && out_vtx.last_vertex |=> state_r == S_IDLE)
    else $error("sequencer busy after final word");

  a_clip_only: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_XT) |-> ncl_r)
    else $error("clip divide without a clipped vertex");
`endif

endmodule

[hdl/tccv_div.sv]
`timescale 1ns / 1ps

module tccv_div import tccv_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  arith_req_t req,
  output div_rsp_t   rsp
);

  localparam int DVW = DIV_STEPS;
  localparam int CW  = $clog2(DIV_STEPS + 1);

  logic           busy_r, busy_nxt;
  logic           done_r, done_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic [DVW-1:0] dvd_r, dvd_nxt;
  logic [OPW:0]   rem_r, rem_nxt;
  logic [OPW-1:0] dmag_r, dmag_nxt;
  logic           neg_r, neg_nxt;
  logic           npos_r, npos_nxt;
  logic           nneg_r, nneg_nxt;
  logic           dz_r, dz_nxt;

  logic [OPW:0]   rem_sh;
  logic           ge;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    dmag_nxt = dmag_r;
    neg_nxt  = neg_r;
    npos_nxt = npos_r;
    nneg_nxt = nneg_r;
    dz_nxt   = dz_r;
    rem_sh   = {rem_r[OPW-1:0], dvd_r[DVW-1]};
    ge       = rem_sh >= {1'b0, dmag_r};
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(DIV_STEPS);
      dvd_nxt  = {(req.a[OPW-1] ? (~req.a + 1'b1) : req.a), {FRAC{1'b0}}};
      dmag_nxt = req.b[OPW-1] ? (~req.b + 1'b1) : req.b;
      rem_nxt  = '0;
      neg_nxt  = req.a[OPW-1] ^ req.b[OPW-1];
      nneg_nxt = req.a[OPW-1];
      npos_nxt = !req.a[OPW-1] && (req.a != '0);
      dz_nxt   = req.b == '0;
    end else if (busy_r) begin
      // One restoring step per cycle; the quotient shifts in behind the dividend.
      rem_nxt = ge ? (rem_sh - {1'b0, dmag_r}) : rem_sh;
      dvd_nxt = {dvd_r[DVW-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r  <= dvd_nxt;
    rem_r  <= rem_nxt;
    dmag_r <= dmag_nxt;
    neg_r  <= neg_nxt;
    npos_r <= npos_nxt;
    nneg_r <= nneg_nxt;
    dz_r   <= dz_nxt;
  end

  always_comb begin
    rsp.done = done_r;
    if (dz_r) begin
      rsp.q = npos_r ? S32_MAX : (nneg_r ? S32_MIN : '0);
    end else if (!neg_r) begin
      rsp.q = (|dvd_r[DVW-1:XW-1]) ? S32_MAX : dvd_r[XW-1:0];
    end else if ((|dvd_r[DVW-1:XW]) || (dvd_r[XW-1] && (|dvd_r[XW-2:0]))) begin
      rsp.q = S32_MIN;
    end else begin
      rsp.q = ~dvd_r[XW-1:0] + 1'b1;
    end
  end

endmodule

[hdl/tccv_mul.sv]
`timescale 1ns / 1ps

module tccv_mul import tccv_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  arith_req_t req,
  output mul_rsp_t   rsp
);

  localparam int CW = $clog2(MUL_STEPS + 1);

  logic           busy_r, busy_nxt;
  logic           done_r, done_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic [PW-1:0]  acc_r, acc_nxt;
  logic [PW-1:0]  mc_r, mc_nxt;
  logic [OPW-1:0] mp_r, mp_nxt;
  logic           neg_r, neg_nxt;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    mc_nxt   = mc_r;
    mp_nxt   = mp_r;
    neg_nxt  = neg_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(MUL_STEPS);
      acc_nxt  = '0;
      mc_nxt   = {{(PW-OPW){1'b0}}, (req.a[OPW-1] ? (~req.a + 1'b1) : req.a)};
      mp_nxt   = req.b[OPW-1] ? (~req.b + 1'b1) : req.b;
      neg_nxt  = req.a[OPW-1] ^ req.b[OPW-1];
    end else if (busy_r) begin
      if (mp_r[0]) acc_nxt = acc_r + mc_r;
      mc_nxt  = {mc_r[PW-2:0], 1'b0};
      mp_nxt  = {1'b0, mp_r[OPW-1:1]};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    acc_r <= acc_nxt;
    mc_r  <= mc_nxt;
    mp_r  <= mp_nxt;
    neg_r <= neg_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.p    = neg_r ? (~acc_r + 1'b1) : acc_r;

endmodule

[tb/triangle_clip_cull_viewport_core_tb.sv]
`timescale 1ns / 1ps

module triangle_clip_cull_viewport_core_tb;
  import tccv_pkg::*;

  localparam longint QONE = 65536;
  localparam longint SMAX = 64'sd2147483647;
  localparam longint SMIN = -64'sd2147483648;
  localparam int STALL_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 2000;

  typedef struct {
    longint x, y, z, w, u, v;
    logic [15:0] s;
  } pvtx_t;

  typedef struct {
    logic [31:0] sx, sy, z, w, u, v;
    logic [15:0] shade;
    logic [1:0]  corner;
    logic        last;
  } screen_vtx_t;

  // Tracks the triangle assembly state and holds the vertices the block owes.
  class clip_scoreboard;
    screen_vtx_t pending[$];
    pvtx_t       held[2];
    int          vcount;
    longint      near_w, cull, width, height;
    int          errors;

    function new();
      vcount = 0; near_w = 6554; cull = 0; width = 640; height = 480; errors = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [30:0] data);
      case (idx)
        CFG_NEAR_W: near_w = data;
        CFG_CULL:   cull = data[1:0];
        CFG_WIDTH:  width = data[12:0];
        CFG_HEIGHT: height = data[12:0];
        default: ;
      endcase
    endfunction

    function longint sat32(longint v);
      return v > SMAX ? SMAX : (v < SMIN ? SMIN : v);
    endfunction

    function longint qdiv(longint num, longint den);
      if (den == 0) return num > 0 ? SMAX : (num < 0 ? SMIN : 0);
      return sat32((num * QONE) / den);
    endfunction

    function longint lerp(longint t, longint a, longint b);
      return sat32(b + (t * (b - a)) / QONE);
    endfunction

    function longint satd(longint v);
      return v > SMAX ? SMAX : (v < -SMAX ? -SMAX : v);
    endfunction

    function pvtx_t near_cross(pvtx_t a, pvtx_t b);
      pvtx_t r;
      longint t;
      t = qdiv(near_w - b.w, b.w - a.w);
      r = a;
      r.x = lerp(t, a.x, b.x);
      r.y = lerp(t, a.y, b.y);
      r.z = lerp(t, a.z, b.z);
      r.w = near_w;
      r.u = lerp(t, a.u, b.u);
      r.v = lerp(t, a.v, b.v);
      return r;
    endfunction

    function int project_tri(pvtx_t p0, pvtx_t p1, pvtx_t p2);
      pvtx_t t[3];
      pvtx_t sv;
      longint nx[3], ny[3];
      longint q, e1x, e1y, e2x, e2y;
      int lx, hx, ly, hy;
      bit back;
      screen_vtx_t o;
      t[0] = p0; t[1] = p1; t[2] = p2;
      lx = 0; hx = 0; ly = 0; hy = 0;
      for (int i = 0; i < 3; i++) begin
        nx[i] = qdiv(t[i].x, t[i].w);
        ny[i] = qdiv(t[i].y, t[i].w);
        lx += (nx[i] < -QONE); hx += (nx[i] > QONE);
        ly += (ny[i] < -QONE); hy += (ny[i] > QONE);
      end
      if (lx == 3 || hx == 3 || ly == 3 || hy == 3) return 0;
      e1x = satd(nx[1] - nx[0]); e1y = satd(ny[1] - ny[0]);
      e2x = satd(nx[2] - nx[0]); e2y = satd(ny[2] - ny[0]);
      back = (e2x * e1y - e2y * e1x) > 0;
      if (cull == CULL_BACK_ONLY && !back) return 0;
      if (cull == CULL_DROP_BACK && back) return 0;
      if (back) begin
        sv = t[0]; t[0] = t[2]; t[2] = sv;
        q = nx[0]; nx[0] = nx[2]; nx[2] = q;
        q = ny[0]; ny[0] = ny[2]; ny[2] = q;
      end
      for (int i = 0; i < 3; i++) begin
        o.sx = sat32(((nx[i] + QONE) * width) / 2);
        o.sy = sat32(((ny[i] + QONE) * height) / 2);
        o.z = t[i].z; o.w = t[i].w; o.u = t[i].u; o.v = t[i].v;
        o.shade = t[i].s;
        o.corner = i;
        o.last = 1'b0;
        pending.push_back(o);
      end
      return 3;
    endfunction

    function void note_input(vtx_t iv);
      pvtx_t c, v[3], vin[3], vout[3], c0, c1;
      int ni, no, n;
      c.x = longint'($signed(iv.x)); c.y = longint'($signed(iv.y));
      c.z = longint'($signed(iv.z)); c.w = longint'($signed(iv.w));
      c.u = longint'($signed(iv.u)); c.v = longint'($signed(iv.v));
      c.s = iv.s;
      if (vcount < 2) begin
        held[vcount & 1] = c;
        vcount++;
        return;
      end
      vcount = 0;
      v[0] = held[0]; v[1] = held[1]; v[2] = c;
      ni = 0; no = 0; n = 0;
      for (int i = 0; i < 3; i++) begin
        if (v[i].w < near_w) begin
          vout[no] = v[i]; no++;
        end else begin
          vin[ni] = v[i]; ni++;
        end
      end
      if (no == 0) begin
        n = project_tri(v[0], v[1], v[2]);
      end else if (no == 1) begin
        c0 = near_cross(vin[1], vout[0]);
        c1 = near_cross(vout[0], vin[0]);
        n = project_tri(vin[0], c0, c1);
        n += project_tri(vin[0], vin[1], c0);
      end else if (no == 2) begin
        n = project_tri(vin[0], near_cross(vin[0], vout[0]), near_cross(vout[1], vin[0]));
      end
      if (n > 0) pending[$].last = 1'b1;
    endfunction

    function void check_word(screen_vtx_t got);
      screen_vtx_t e;
      if (pending.size() == 0) begin
        $error("unexpected output word: screen_x %h screen_y %h", got.sx, got.sy);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.sx !== e.sx) begin
        $error("screen_x exp %h got %h", e.sx, got.sx); errors++;
      end
      if (got.sy !== e.sy) begin
        $error("screen_y exp %h got %h", e.sy, got.sy); errors++;
      end
      if (got.z !== e.z) begin
        $error("out_z exp %h got %h", e.z, got.z); errors++;
      end
      if (got.w !== e.w) begin
        $error("out_w exp %h got %h", e.w, got.w); errors++;
      end
      if (got.u !== e.u) begin
        $error("out_u exp %h got %h", e.u, got.u); errors++;
      end
      if (got.v !== e.v) begin
        $error("out_v exp %h got %h", e.v, got.v); errors++;
      end
      if (got.shade !== e.shade) begin
        $error("out_shade exp %h got %h", e.shade, got.shade); errors++;
      end
      if (got.corner !== e.corner) begin
        $error("corner exp %0d got %0d", e.corner, got.corner); errors++;
      end
      if (got.last !== e.last) begin
        $error("last_vertex exp %0b got %0b", e.last, got.last); errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [30:0] cfg_data;

  tccv_in_if  in_vtx();
  tccv_out_if out_vtx();

  triangle_clip_cull_viewport_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_vtx    (in_vtx),
    .out_vtx   (out_vtx),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  clip_scoreboard sb;
  int  burst_left;
  int  idle_cycles;
  int  hold_cnt;
  int  rx_phase;
  bit  hold_req;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    sb = new();
    rst_n = 1'b0;
    cfg_we = 1'b0; cfg_index = CFG_NEAR_W; cfg_data = '0;
    in_vtx.valid = 1'b0;
    in_vtx.clip_x = '0; in_vtx.clip_y = '0; in_vtx.clip_z = '0; in_vtx.clip_w = '0;
    in_vtx.tex_u = '0; in_vtx.tex_v = '0; in_vtx.shade = '0;
    out_vtx.ready = 1'b0;
    burst_left = 0; hold_cnt = 0; rx_phase = 0; hold_req = 1'b0; idle_cycles = 0;
  end

  // Output side stalls at random, with fully open stretches and one long hold-off.
  always @(posedge clk) begin
    rx_phase <= (rx_phase + 1) % 1000;
    if (hold_cnt > 0) begin
      out_vtx.ready <= 1'b0;
      hold_cnt <= hold_cnt - 1;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_cnt <= 3000;
      out_vtx.ready <= 1'b0;
    end else if (rx_phase < 300) begin
      out_vtx.ready <= 1'b1;
    end else begin
      out_vtx.ready <= ($urandom_range(0, 3) != 0);
    end
  end

  always @(posedge clk) begin
    screen_vtx_t w;
    if (rst_n && in_vtx.valid && in_vtx.ready)
      sb.note_input('{in_vtx.clip_x, in_vtx.clip_y, in_vtx.clip_z, in_vtx.clip_w,
                      in_vtx.tex_u, in_vtx.tex_v, in_vtx.shade});
    if (rst_n && out_vtx.valid && out_vtx.ready) begin
      w.sx = out_vtx.screen_x; w.sy = out_vtx.screen_y;
      w.z = out_vtx.out_z; w.w = out_vtx.out_w;
      w.u = out_vtx.out_u; w.v = out_vtx.out_v;
      w.shade = out_vtx.out_shade; w.corner = out_vtx.corner;
      w.last = out_vtx.last_vertex;
      sb.check_word(w);
    end
  end

  always @(posedge clk) begin
    if ((in_vtx.valid && in_vtx.ready) || (out_vtx.valid && out_vtx.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("triangle_clip_cull_viewport_core regression: fail");
      $finish;
    end
  end

  function automatic vtx_t mk(longint x, longint y, longint z, longint w,
                              longint u, longint v, logic [15:0] s);
    vtx_t r;
    r.x = x; r.y = y; r.z = z; r.w = w; r.u = u; r.v = v; r.s = s;
    return r;
  endfunction

  function automatic vtx_t any_vtx();
    return mk($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
  endfunction

  // Mostly near the visible volume; a quarter of the time behind the near plane.
  function automatic vtx_t shaped_vtx(longint near);
    longint w;
    w = near + longint'($urandom_range(0, 4 * 65536));
    if ($urandom_range(0, 3) == 0) w = near - 1 - longint'($urandom_range(0, 3 * 65536));
    if (w > SMAX) w = SMAX;
    if (w < SMIN) w = SMIN;
    return mk((w * (longint'($urandom_range(0, 6000)) - 3000)) / 2000,
              (w * (longint'($urandom_range(0, 6000)) - 3000)) / 2000,
              $urandom, w, $urandom, $urandom, $urandom);
  endfunction

  task automatic send_vtx(vtx_t v);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 3) != 0) begin
        gap = $urandom_range(1, 20);
        in_vtx.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_vtx.valid <= 1'b1;
    in_vtx.clip_x <= v.x; in_vtx.clip_y <= v.y; in_vtx.clip_z <= v.z;
    in_vtx.clip_w <= v.w; in_vtx.tex_u <= v.u; in_vtx.tex_v <= v.v;
    in_vtx.shade <= v.s;
    do @(posedge clk); while (!in_vtx.ready);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [30:0] data);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= data;
    sb.set_reg(idx, data);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    in_vtx.valid <= 1'b0;
    burst_left = 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic run_random(int tris, bit with_hold);
    longint near;
    near = sb.near_w;
    for (int t = 0; t < tris; t++) begin
      if (with_hold && t == tris / 2) hold_req = 1'b1;
      for (int k = 0; k < 3; k++) begin
        if ($urandom_range(0, 4) == 0) send_vtx(any_vtx());
        else send_vtx(shaped_vtx(near));
      end
    end
  endtask

  task automatic configure(logic [30:0] near, logic [1:0] cull, logic [12:0] w, logic [12:0] h);
    write_reg(CFG_NEAR_W, near);
    write_reg(CFG_CULL, cull);
    write_reg(CFG_WIDTH, w);
    write_reg(CFG_HEIGHT, h);
  endtask

  localparam longint Q = 65536;

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Plain front face, then the same triangle wound the other way.
    send_vtx(mk(0, 0, Q, Q, 0, 0, 16'h0100));
    send_vtx(mk(Q / 2, 0, Q, Q, Q, 0, 16'h0200));
    send_vtx(mk(0, Q / 2, Q, Q, 0, Q, 16'h0300));
    send_vtx(mk(0, Q / 2, Q, Q, 0, Q, 16'h0300));
    send_vtx(mk(Q / 2, 0, Q, Q, Q, 0, 16'h0200));
    send_vtx(mk(0, 0, Q, Q, 0, 0, 16'h0100));
    // One vertex behind the near plane, then two, then all three.
    send_vtx(mk(0, 0, Q, 0, 0, 0, 16'h0011));
    send_vtx(mk(Q / 2, 0, Q, Q, Q, 0, 16'h0022));
    send_vtx(mk(0, Q / 2, Q, 2 * Q, 0, Q, 16'h0033));
    send_vtx(mk(Q / 4, 0, Q, -Q, 0, 0, 16'h0044));
    send_vtx(mk(0, Q / 4, Q, Q, Q, 0, 16'h0055));
    send_vtx(mk(Q / 4, Q / 4, Q, 100, 0, Q, 16'h0066));
    send_vtx(mk(0, 0, Q, -Q, 0, 0, 0));
    send_vtx(mk(Q, 0, Q, -2 * Q, 0, 0, 0));
    send_vtx(mk(0, Q, Q, 6553, 0, 0, 0));
    // Wholly right of the viewport, then a zero-area triangle.
    send_vtx(mk(2 * Q, 0, 0, Q, 0, 0, 1));
    send_vtx(mk(3 * Q, Q, 0, Q, 0, 0, 2));
    send_vtx(mk(4 * Q, -Q, 0, Q, 0, 0, 3));
    send_vtx(mk(Q / 8, Q / 8, 0, Q, 0, 0, 4));
    send_vtx(mk(Q / 8, Q / 8, 0, Q, 0, 0, 5));
    send_vtx(mk(Q / 8, Q / 8, 0, Q, 0, 0, 6));
    // Field extremes.
    send_vtx(mk(SMAX, SMIN, SMAX, SMAX, SMIN, SMAX, 16'hffff));
    send_vtx(mk(SMIN, SMAX, SMIN, SMAX, SMAX, SMIN, 16'h0000));
    send_vtx(mk(SMAX, SMAX, 0, SMIN, -1, -1, 16'h8000));
    drain();

    run_random(27, 1'b0);
    drain();
    configure(31'd1, CULL_BACK_ONLY, 13'd4096, 13'd4096);
    run_random(27, 1'b0);
    drain();
    configure(31'h7fffffff, CULL_DROP_BACK, 13'd1, 13'd1);
    run_random(20, 1'b0);
    drain();
    configure(31'd65536, 2'd3, 13'd320, 13'd240);
    run_random(30, 1'b1);
    drain();
    configure(31'd6554, CULL_DROP_BACK, 13'd4096, 13'd1);
    run_random(27, 1'b0);
    drain();
    configure(31'd30000, 2'd0, 13'd1024, 13'd768);
    run_random(27, 1'b0);
    drain();

    if (sb.errors == 0) begin
      $display("triangle_clip_cull_viewport_core regression: pass");
    end else begin
      $display("triangle_clip_cull_viewport_core regression: fail");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/tccv_pkg.sv
hdl/tccv_if.sv
hdl/tccv_div.sv
hdl/tccv_mul.sv
hdl/triangle_clip_cull_viewport_core.sv
tb/triangle_clip_cull_viewport_core_tb.sv
